FILE: src/scc_pkg.sv
// Shared constants and types for the serial cluster covariance block.
// No dependencies.
package scc_pkg;
  localparam int DefMaxObs = 1024;
  localparam int DefMaxCov = 8;
  localparam int FieldW = 16;
  localparam int AccW = 64;

  localparam logic [0:0] CFG_CUTOFF = 1'b0;
  localparam logic [0:0] CFG_NUMCOV = 1'b1;

  typedef struct packed {
    logic load;      // store the input word
    logic clr_acc;   // clear flags at the end of a set
    logic rd_i;      // read observation i
    logic rd_j;      // read observation j
    logic acc_en;    // accumulate the current product
    logic emit;      // current entry taken by the receiver
  } scc_cmd_t;

  typedef struct packed {
    logic pair_ok;   // i and j pair
    logic full;      // store holds MAX_OBS words
  } scc_sts_t;
endpackage

FILE: src/serial_cluster_covariance_meat.sv
// After the last word: a read of row i per i; per pair (i,j) a read of row j and a
// wait, then multiply-accumulates over all k*k column pairs when the pair matches, else
// a single test; then a drain, then k*k result words (one per cycle if taken).
// Throughput: one observation word per cycle while loading; input refused until the
// last result word is taken. Reset (rst_n, synchronous): count, flags and sum valid
// bits cleared, so every sum reads as zero; stores undefined.
module serial_cluster_covariance_meat #(
  parameter int MAX_OBS = scc_pkg::DefMaxObs,
  parameter int MAX_COVARIATES = scc_pkg::DefMaxCov
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_obs_time,
  input  logic [15:0] in_obs_id,
  input  logic signed [15:0] in_residual,
  input  logic signed [15:0] in_cov_0,
  input  logic signed [15:0] in_cov_1,
  input  logic signed [15:0] in_cov_2,
  input  logic signed [15:0] in_cov_3,
  input  logic signed [15:0] in_cov_4,
  input  logic signed [15:0] in_cov_5,
  input  logic signed [15:0] in_cov_6,
  input  logic signed [15:0] in_cov_7,
  input  logic        in_last_obs,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row_index,
  output logic [2:0]  out_col_index,
  output logic signed [63:0] out_entry_value,
  output logic        out_last_entry,
  output logic        out_saturated,
  output logic        out_dropped
);
  import scc_pkg::*;

  localparam int AW = $clog2(MAX_OBS);
  localparam int CW = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1;

  logic [15:0] cutoff_r;
  logic [3:0]  numcov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      numcov_r <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CUTOFF) cutoff_r <= cfg_data;
      if (cfg_index == CFG_NUMCOV) numcov_r <= cfg_data[3:0];
    end
  end

  logic [16*8-1:0] cov_all;
  assign cov_all = {in_cov_7, in_cov_6, in_cov_5, in_cov_4,
                    in_cov_3, in_cov_2, in_cov_1, in_cov_0};

  scc_cmd_t cmd;
  scc_sts_t sts;
  logic [AW:0] count;
  logic [AW-1:0] idx_i, idx_j;
  logic [CW-1:0] acc_a, acc_b, out_a, out_b, rd_a, rd_b;
  logic in_fire, drop_set;
  assign in_fire = in_valid && in_ready;

  scc_ctrl #(.MaxObs(MAX_OBS), .MaxCov(MAX_COVARIATES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_last_obs),
    .numcov(numcov_r), .sts(sts), .cmd(cmd), .count(count),
    .idx_i(idx_i), .idx_j(idx_j), .acc_a(acc_a), .acc_b(acc_b),
    .out_a(out_a), .out_b(out_b), .rd_a(rd_a), .rd_b(rd_b),
    .in_ready(in_ready), .out_valid(out_valid),
    .out_last(out_last_entry), .out_ready(out_ready), .drop_set(drop_set)
  );

  scc_datapath #(.MaxObs(MAX_OBS), .MaxCov(MAX_COVARIATES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .count(count),
    .idx_i(idx_i), .idx_j(idx_j), .acc_a(acc_a), .acc_b(acc_b),
    .out_a(rd_a), .out_b(rd_b), .cutoff(cutoff_r),
    .in_time(in_obs_time), .in_id(in_obs_id), .in_res(in_residual),
    .in_cov(cov_all[16*MAX_COVARIATES-1:0]), .drop_set(drop_set),
    .entry(out_entry_value), .sat_flag(out_saturated), .drop_flag(out_dropped)
  );

  assign out_row_index = 3'(out_a);
  assign out_col_index = 3'(out_b);
endmodule

FILE: src/scc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module scc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/scc_datapath.sv
// Datapath: observation store, pair test, product chain and accumulators.
// Depends on scc_pkg and scc_ram.
module scc_datapath #(
  parameter int MaxObs = scc_pkg::DefMaxObs,
  parameter int MaxCov = scc_pkg::DefMaxCov,
  localparam int AW = $clog2(MaxObs),
  localparam int CW = (MaxCov > 1) ? $clog2(MaxCov) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scc_pkg::scc_cmd_t    cmd,
  output scc_pkg::scc_sts_t    sts,
  input  logic [AW:0]          count,
  input  logic [AW-1:0]        idx_i,
  input  logic [AW-1:0]        idx_j,
  input  logic [CW-1:0]        acc_a,   // accumulate column pair (a,b)
  input  logic [CW-1:0]        acc_b,
  input  logic [CW-1:0]        out_a,   // entry to fetch for the next cycle
  input  logic [CW-1:0]        out_b,
  input  logic [15:0]          cutoff,
  input  logic [15:0]          in_time,
  input  logic [15:0]          in_id,
  input  logic signed [15:0]   in_res,
  input  logic [16*MaxCov-1:0] in_cov,
  input  logic                 drop_set,
  output logic signed [63:0]   entry,
  output logic                 sat_flag,
  output logic                 drop_flag
);
  import scc_pkg::*;

  localparam int RowW = 48 + 16 * MaxCov;
  localparam int PW = 2 * CW;
  localparam int AccDepth = 1 << PW;

  logic [RowW-1:0] wrow, rrow_i, rrow_j;
  logic [RowW-1:0] row_i_r, row_j_r;
  logic [AW-1:0]   raddr;
  logic            rd_i_r, rd_j_r;

  assign wrow  = {in_time, in_id, in_res, in_cov};
  assign raddr = cmd.rd_i ? idx_i : idx_j;

  scc_ram #(.Width(RowW), .Depth(MaxObs)) u_store (
    .clk(clk), .we(cmd.load), .waddr(count[AW-1:0]), .wdata(wrow),
    .raddr(raddr), .rdata(rrow_i)
  );
  assign rrow_j = rrow_i;

  // i row is latched on the cycle after its read, j row likewise
  always_ff @(posedge clk) begin
    rd_i_r <= cmd.rd_i;
    rd_j_r <= cmd.rd_j;
    if (rd_i_r) row_i_r <= rrow_i;
    if (rd_j_r) row_j_r <= rrow_j;
  end

  logic [15:0] ti, tj, ui, uj, gap;
  assign ti  = row_i_r[RowW-1 -: 16];
  assign tj  = row_j_r[RowW-1 -: 16];
  assign ui  = row_i_r[RowW-17 -: 16];
  assign uj  = row_j_r[RowW-17 -: 16];
  assign gap = (ti > tj) ? ti - tj : tj - ti;
  assign sts.pair_ok = (ui == uj) && (gap <= cutoff);
  assign sts.full    = (count == (AW+1)'(MaxObs));

  // stage 1: ee and xx; stage 2: 64-bit product and sum read; stage 3: write back
  logic signed [15:0] ri, rj, xa, xb;
  logic signed [31:0] ee_r, xx_r;
  logic signed [63:0] p_r;
  logic               v1_r, v2_r;
  logic [CW-1:0]      a1_r, b1_r, a2_r, b2_r;
  assign ri = row_i_r[16*MaxCov +: 16];
  assign rj = row_j_r[16*MaxCov +: 16];
  assign xa = row_i_r[16*acc_a +: 16];
  assign xb = row_j_r[16*acc_b +: 16];

  always_ff @(posedge clk) begin
    ee_r <= ri * rj;
    xx_r <= xa * xb;
    a1_r <= acc_a; b1_r <= acc_b;
    p_r  <= 64'(ee_r) * 64'(xx_r);
    a2_r <= a1_r; b2_r <= b1_r;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.acc_en;
      v2_r <= v1_r;
    end
  end

  // Sums live in a RAM; a valid bit per entry makes a never-written or
  // already emitted entry read as zero.
  logic [PW-1:0]      acc_ra, acc_wa, acc_ra_r;
  logic [AccW-1:0]    acc_rd, acc_wd;
  logic [AccDepth-1:0] vld_r;
  logic               vld_rd_r;
  logic signed [63:0] cur, sum;
  logic               ovf;

  assign acc_ra = v1_r ? {a1_r, b1_r} : {out_a, out_b};
  assign acc_wa = {a2_r, b2_r};

  scc_ram #(.Width(AccW), .Depth(AccDepth)) u_acc (
    .clk(clk), .we(v2_r), .waddr(acc_wa), .wdata(acc_wd),
    .raddr(acc_ra), .rdata(acc_rd)
  );

  always_ff @(posedge clk) begin
    acc_ra_r <= acc_ra;
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      vld_rd_r <= vld_r[acc_ra];
      if (v2_r) vld_r[acc_wa] <= 1'b1;
      if (cmd.emit) vld_r[acc_ra_r] <= 1'b0;
    end
  end

  assign cur = vld_rd_r ? $signed(acc_rd) : 64'sd0;
  assign sum = cur + p_r;
  assign ovf = (cur[63] == p_r[63]) && (sum[63] != cur[63]);
  assign acc_wd = ovf ? (cur[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_acc) begin
      sat_flag  <= 1'b0;
      drop_flag <= 1'b0;
    end else begin
      if (v2_r && ovf) sat_flag <= 1'b1;
      if (drop_set) drop_flag <= 1'b1;
    end
  end

  assign entry = vld_rd_r ? $signed(acc_rd) : 64'sd0;
endmodule

FILE: src/scc_ctrl.sv
// Controller: load counter, pair walk over (i,j,a,b), drain and emit.
// Depends on scc_pkg.
module scc_ctrl #(
  parameter int MaxObs = scc_pkg::DefMaxObs,
  parameter int MaxCov = scc_pkg::DefMaxCov,
  localparam int AW = $clog2(MaxObs),
  localparam int CW = (MaxCov > 1) ? $clog2(MaxCov) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  input  logic [3:0]        numcov,
  input  scc_pkg::scc_sts_t sts,
  output scc_pkg::scc_cmd_t cmd,
  output logic [AW:0]       count,
  output logic [AW-1:0]     idx_i,
  output logic [AW-1:0]     idx_j,
  output logic [CW-1:0]     acc_a,
  output logic [CW-1:0]     acc_b,
  output logic [CW-1:0]     out_a,
  output logic [CW-1:0]     out_b,
  output logic [CW-1:0]     rd_a,
  output logic [CW-1:0]     rd_b,
  output logic              in_ready,
  output logic              out_valid,
  output logic              out_last,
  input  logic              out_ready,
  output logic              drop_set
);
  import scc_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0, S_RDI = 3'd1, S_RDJ = 3'd2,
                         S_WAIT = 3'd3, S_MAC = 3'd4, S_DRAIN = 3'd5,
                         S_EMIT = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW:0]   count_r, i_r, j_r;
  logic [CW-1:0] a_r, b_r;
  logic [1:0]    wait_r;
  logic [CW:0]   k;

  always_comb begin
    if (numcov == 4'd0) k = (CW+1)'(1);
    else if (numcov > 4'(MaxCov)) k = (CW+1)'(MaxCov);
    else k = (CW+1)'(numcov);
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EMIT);
  assign count = count_r;
  assign idx_i = i_r[AW-1:0];
  assign idx_j = j_r[AW-1:0];
  assign acc_a = a_r; assign acc_b = b_r;
  assign out_a = a_r; assign out_b = b_r;
  assign out_last = ((CW+1)'(a_r) == k - 1'b1) && ((CW+1)'(b_r) == k - 1'b1);
  assign drop_set = in_fire && sts.full;

  // registered sum read: fetch the entry that is shown next cycle
  always_comb begin
    rd_a = a_r;
    rd_b = b_r;
    if (state_r == S_EMIT && out_ready && !out_last) begin
      if ((CW+1)'(b_r) == k - 1'b1) begin
        rd_a = a_r + 1'b1;
        rd_b = '0;
      end else begin
        rd_b = b_r + 1'b1;
      end
    end
  end

  logic last_ab;
  assign last_ab = out_last;

  always_comb begin
    cmd = '0;
    cmd.load   = in_fire && !sts.full;
    cmd.rd_i   = (state_r == S_RDI);
    cmd.rd_j   = (state_r == S_RDJ);
    cmd.acc_en = (state_r == S_MAC) && sts.pair_ok;
    cmd.emit   = out_valid && out_ready;
    cmd.clr_acc = out_valid && out_ready && out_last;
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (in_fire && in_last)
                 state_nxt = (count_r == '0 && sts.full) ? S_DRAIN :
                             ((count_r + (cmd.load ? 1'b1 : 1'b0)) == '0) ? S_DRAIN : S_RDI;
      S_RDI:   state_nxt = S_RDJ;
      S_RDJ:   state_nxt = S_WAIT;
      S_WAIT:  if (wait_r == 2'd1) state_nxt = S_MAC;
      S_MAC:   if (!sts.pair_ok || last_ab) begin
                 if (j_r + 1'b1 == count_r)
                   state_nxt = (i_r + 1'b1 == count_r) ? S_DRAIN : S_RDI;
                 else
                   state_nxt = S_RDJ;
               end
      S_DRAIN: if (wait_r == 2'd3) state_nxt = S_EMIT;
      S_EMIT:  if (out_ready && out_last) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      i_r <= '0; j_r <= '0; a_r <= '0; b_r <= '0; wait_r <= '0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= (state_r == state_nxt) ? wait_r + 1'b1 : 2'd0;
      case (state_r)
        S_LOAD: begin
          if (cmd.load) count_r <= count_r + 1'b1;
          i_r <= '0; j_r <= '0; a_r <= '0; b_r <= '0;
        end
        S_MAC: begin
          if (!sts.pair_ok || last_ab) begin
            a_r <= '0; b_r <= '0;
            if (j_r + 1'b1 == count_r) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else if ((CW+1)'(b_r) == k - 1'b1) begin
            b_r <= '0; a_r <= a_r + 1'b1;
          end else begin
            b_r <= b_r + 1'b1;
          end
        end
        S_DRAIN: begin a_r <= '0; b_r <= '0; end
        S_EMIT: if (out_ready) begin
          if (out_last) begin
            count_r <= '0;
            a_r <= '0; b_r <= '0;
          end else begin
            a_r <= rd_a; b_r <= rd_b;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("load and emit overlap");
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(MaxObs)) else $error("count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready) else $error("no return to load");
endmodule

FILE: sim/scc_checker.sv
// Checker for serial_cluster_covariance_meat: watches config writes and both
// word channels, predicts each matrix entry and compares it with the block.
// Depends on scc_pkg.
module scc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_obs_time,
  input  logic [15:0] in_obs_id,
  input  logic signed [15:0] in_residual,
  input  logic signed [15:0] in_cov_0,
  input  logic signed [15:0] in_cov_1,
  input  logic signed [15:0] in_cov_2,
  input  logic signed [15:0] in_cov_3,
  input  logic signed [15:0] in_cov_4,
  input  logic signed [15:0] in_cov_5,
  input  logic signed [15:0] in_cov_6,
  input  logic signed [15:0] in_cov_7,
  input  logic        in_last_obs,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_row_index,
  input  logic [2:0]  out_col_index,
  input  logic signed [63:0] out_entry_value,
  input  logic        out_last_entry,
  input  logic        out_saturated,
  input  logic        out_dropped,
  output int          pending,
  output int          errors
);
  import scc_pkg::*;

  localparam int ObsDepth = DefMaxObs;
  localparam int CovMax = DefMaxCov;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [63:0] sum;
    logic               last;
    logic               sat;
    logic               drop;
  } entry_t;

  entry_t entry_q[$];

  logic [15:0]        obs_t [ObsDepth];
  logic [15:0]        obs_u [ObsDepth];
  logic signed [15:0] obs_r [ObsDepth];
  logic signed [15:0] obs_x [ObsDepth][CovMax];
  logic [63:0]        meat [CovMax][CovMax];
  int                 n_obs;
  logic               sat_seen, drop_seen;
  logic [15:0]        cutoff;
  logic [3:0]         ncov;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat_seen = 1'b1;
      r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  // Walk every ordered pair in the set, then queue the k*k entries row-major.
  function automatic void close_set();
    int k, gap;
    logic signed [31:0] ee, xx;
    logic signed [63:0] p;
    entry_t e;
    k = (ncov == 0) ? 1 : (ncov > CovMax) ? CovMax : ncov;
    for (int i = 0; i < n_obs; i++)
      for (int j = 0; j < n_obs; j++) begin
        gap = (obs_t[i] > obs_t[j]) ? obs_t[i] - obs_t[j] : obs_t[j] - obs_t[i];
        if (obs_u[i] == obs_u[j] && gap <= cutoff) begin
          ee = obs_r[i] * obs_r[j];
          for (int a = 0; a < k; a++)
            for (int b = 0; b < k; b++) begin
              xx = obs_x[i][a] * obs_x[j][b];
              p = ee * xx;
              meat[a][b] = sat_sum(meat[a][b], p);
            end
        end
      end
    for (int a = 0; a < k; a++)
      for (int b = 0; b < k; b++) begin
        e.row = a[2:0];
        e.col = b[2:0];
        e.sum = meat[a][b];
        e.last = (a == k - 1 && b == k - 1);
        e.sat = sat_seen;
        e.drop = drop_seen;
        entry_q.push_back(e);
      end
    for (int a = 0; a < CovMax; a++)
      for (int b = 0; b < CovMax; b++) meat[a][b] = '0;
    n_obs = 0;
    sat_seen = 1'b0;
    drop_seen = 1'b0;
  endfunction

  always @(posedge clk) begin
    entry_t e;
    if (!rst_n) begin
      entry_q.delete();
      for (int a = 0; a < CovMax; a++)
        for (int b = 0; b < CovMax; b++) meat[a][b] = '0;
      n_obs = 0;
      sat_seen = 1'b0;
      drop_seen = 1'b0;
      cutoff = '0;
      ncov = 4'd8;
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CUTOFF) cutoff = cfg_data;
        else if (cfg_index == CFG_NUMCOV) ncov = cfg_data[3:0];
      end
      if (out_valid && out_ready) begin
        if (entry_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = entry_q.pop_front();
          if (out_row_index !== e.row) begin
            $error("row_index exp %0d got %0d", e.row, out_row_index); errors++;
          end
          if (out_col_index !== e.col) begin
            $error("col_index exp %0d got %0d", e.col, out_col_index); errors++;
          end
          if (out_entry_value !== e.sum) begin
            $error("entry_value exp %0d got %0d", e.sum, out_entry_value); errors++;
          end
          if (out_last_entry !== e.last) begin
            $error("last_entry exp %0d got %0d", e.last, out_last_entry); errors++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated exp %0d got %0d", e.sat, out_saturated); errors++;
          end
          if (out_dropped !== e.drop) begin
            $error("dropped exp %0d got %0d", e.drop, out_dropped); errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (n_obs < ObsDepth) begin
          obs_t[n_obs] = in_obs_time;
          obs_u[n_obs] = in_obs_id;
          obs_r[n_obs] = in_residual;
          obs_x[n_obs][0] = in_cov_0;
          obs_x[n_obs][1] = in_cov_1;
          obs_x[n_obs][2] = in_cov_2;
          obs_x[n_obs][3] = in_cov_3;
          obs_x[n_obs][4] = in_cov_4;
          obs_x[n_obs][5] = in_cov_5;
          obs_x[n_obs][6] = in_cov_6;
          obs_x[n_obs][7] = in_cov_7;
          n_obs++;
        end else begin
          drop_seen = 1'b1;
        end
        if (in_last_obs) close_set();
      end
    end
    pending = entry_q.size();
  end
endmodule

FILE: sim/tb_top.sv
// Top of the serial_cluster_covariance_meat testbench: clock, reset, stimulus
// and verdict. Depends on scc_pkg, the block and scc_checker.
module tb_top;
  import scc_pkg::*;

  // Longest set: 24 matching words at k = 8.
  localparam int StallLimit = 400_000;

  logic clk, rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic [15:0] in_obs_time, in_obs_id;
  logic signed [15:0] in_residual;
  logic signed [15:0] in_cov [8];
  logic in_last_obs;
  logic out_valid, out_ready;
  logic [2:0] out_row_index, out_col_index;
  logic signed [63:0] out_entry_value;
  logic out_last_entry, out_saturated, out_dropped;
  int pending, errors;
  int tx_idle_pct, rx_idle_pct;
  int stall_cnt;
  int sent;

  serial_cluster_covariance_meat u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_obs_time, .in_obs_id, .in_residual,
    .in_cov_0(in_cov[0]), .in_cov_1(in_cov[1]), .in_cov_2(in_cov[2]),
    .in_cov_3(in_cov[3]), .in_cov_4(in_cov[4]), .in_cov_5(in_cov[5]),
    .in_cov_6(in_cov[6]), .in_cov_7(in_cov[7]), .in_last_obs,
    .out_valid, .out_ready, .out_row_index, .out_col_index, .out_entry_value,
    .out_last_entry, .out_saturated, .out_dropped
  );

  scc_checker u_chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_obs_time, .in_obs_id, .in_residual,
    .in_cov_0(in_cov[0]), .in_cov_1(in_cov[1]), .in_cov_2(in_cov[2]),
    .in_cov_3(in_cov[3]), .in_cov_4(in_cov[4]), .in_cov_5(in_cov[5]),
    .in_cov_6(in_cov[6]), .in_cov_7(in_cov[7]), .in_last_obs,
    .out_valid, .out_ready, .out_row_index, .out_col_index, .out_entry_value,
    .out_last_entry, .out_saturated, .out_dropped, .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt == StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [15:0] t, logic [15:0] id, logic [15:0] r,
                           logic [127:0] x, logic last);
    // each draw under tx_idle_pct idles in_valid, keeping the idle share at tx_idle_pct
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_obs_time <= t;
    in_obs_id <= id;
    in_residual <= r;
    for (int c = 0; c < 8; c++) in_cov[c] <= x[16*c +: 16];
    in_last_obs <= last;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Only called with the block idle: all entries back, then a short drain.
  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [127:0] rand_covs(bit narrow);
    logic [127:0] x;
    for (int c = 0; c < 8; c++)
      x[16*c +: 16] = narrow ? 16'($signed($urandom_range(511)) - 256) : 16'($urandom);
    return x;
  endfunction

  initial begin
    int n, base_t, base_id;
    bit narrow, wide;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CUTOFF;
    cfg_data = '0;
    in_valid = 1'b0;
    in_obs_time = '0;
    in_obs_id = '0;
    in_residual = '0;
    for (int c = 0; c < 8; c++) in_cov[c] = '0;
    in_last_obs = 1'b0;
    out_ready = 1'b0;
    tx_idle_pct = 35;
    rx_idle_pct = 72;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset settings: single observation with extreme fields.
    send_word(16'hFFFF, 16'hFFFF, 16'h7FFF,
              {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0100, 16'hFF00},
              1'b1);
    // Four identical full-scale words: sums clamp at both limits.
    for (int i = 0; i < 4; i++)
      send_word(16'd0, 16'd7, 16'h8000,
                {{6{16'h8000}}, 16'h7FFF, 16'h8000}, i == 3);
    write_reg(CFG_CUTOFF, 16'hFFFF);
    write_reg(CFG_NUMCOV, 16'd0);
    send_word(16'd0, 16'd3, 16'h0123, rand_covs(0), 1'b0);
    send_word(16'hFFFF, 16'd3, 16'hFEDC, rand_covs(0), 1'b0);
    send_word(16'd5, 16'd4, 16'h7FFF, rand_covs(0), 1'b1);
    write_reg(CFG_NUMCOV, 16'd15);
    for (int i = 0; i < 3; i++) send_word(16'(i), 16'd1, 16'($urandom), rand_covs(0), i == 2);
    write_reg(CFG_NUMCOV, 16'd1);
    write_reg(CFG_CUTOFF, 16'd2);
    send_word(16'd10, 16'd9, 16'h0100, rand_covs(0), 1'b0);
    send_word(16'd12, 16'd9, 16'h0200, rand_covs(0), 1'b0);
    send_word(16'd13, 16'd9, 16'hFF00, rand_covs(0), 1'b0);
    send_word(16'd7, 16'd9, 16'h0080, rand_covs(0), 1'b1);

    while (sent < 320) begin
      if (sent > 140 && tx_idle_pct == 35) begin
        tx_idle_pct = 72;
        rx_idle_pct = 35;
      end else if (sent > 260) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(3) == 0)
        write_reg(CFG_CUTOFF, ($urandom_range(4) == 0) ? 16'($urandom) :
                              16'($urandom_range(4)));
      if ($urandom_range(3) == 0) write_reg(CFG_NUMCOV, 16'($urandom_range(15)));
      n = ($urandom_range(14) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
      wide = ($urandom_range(4) == 0);
      base_t = $urandom;
      base_id = $urandom;
      for (int i = 0; i < n; i++) begin
        narrow = ($urandom_range(2) == 0);
        send_word(wide ? 16'($urandom) : 16'(base_t + $urandom_range(5)),
                  wide ? 16'($urandom) : 16'(base_id + $urandom_range(2)),
                  narrow ? 16'($signed($urandom_range(511)) - 256) : 16'($urandom),
                  rand_covs(narrow), i == n - 1);
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
